// File: rtl/ttu_pkg.sv
`timescale 1ns / 1ps
package ttu_pkg;

	localparam int CHAR_W   = 8;
	localparam int RADIX_W  = 6;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;
	localparam int OFFSET_W = 16;
	localparam int DIGIT_W  = 6;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam int QUEUE_DEPTH_DEF = 2;

	// weight used for characters that are a digit in no base
	localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVER   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOCONV = 2'd2;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               is_ws;
		logic               is_sign;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
		logic               start;
	} cls_t;

endpackage

// File: rtl/ttu_char_if.sv
`timescale 1ns / 1ps
interface ttu_char_if;
	logic                        valid;
	logic                        ready;
	logic [ttu_pkg::CHAR_W-1:0]  char_code;
	logic                        start_flag;

	modport source(output valid, char_code, start_flag, input ready);
	modport sink(input valid, char_code, start_flag, output ready);
endinterface

// File: rtl/ttu_result_if.sv
`timescale 1ns / 1ps
interface ttu_result_if;
	logic                          valid;
	logic                          ready;
	logic [ttu_pkg::VALUE_W-1:0]   value;
	logic [ttu_pkg::STATUS_W-1:0]  status;
	logic [ttu_pkg::OFFSET_W-1:0]  end_offset;

	modport source(output valid, value, status, end_offset, input ready);
	modport sink(input valid, value, status, end_offset, output ready);
endinterface

// File: rtl/ttu_cfg_if.sv
`timescale 1ns / 1ps
interface ttu_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [ttu_pkg::RADIX_W-1:0]  radix;

	modport source(output valid, radix, input ready);
	modport sink(input valid, radix, output ready);
endinterface

// File: rtl/ttu_queue.sv
`timescale 1ns / 1ps
module ttu_queue #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = store_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= push_data;
		end
	end
endmodule

// File: rtl/ttu_front.sv
`timescale 1ns / 1ps
module ttu_front (
	ttu_char_if.sink      chars,
	input  logic          q_ready,
	output logic          push,
	output ttu_pkg::cls_t cls
);
	import ttu_pkg::*;

	function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		begin
			d = CHAR_W'(DIGIT_NONE);
			if (c >= 8'h30 && c <= 8'h39) begin
				d = c - 8'h30;
			end else if (c >= 8'h41 && c <= 8'h5A) begin
				d = c - 8'h37;
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				d = c - 8'h57;
			end
			return d[DIGIT_W-1:0];
		end
	endfunction

	assign chars.ready = q_ready;
	assign push        = chars.valid;

	always_comb begin
		cls.digit    = digit_of(chars.char_code);
		// space, tab, newline, vertical tab, form feed, carriage return
		cls.is_ws    = (chars.char_code == 8'h20) ||
		               (chars.char_code >= 8'h09 && chars.char_code <= 8'h0D);
		cls.is_sign  = (chars.char_code == 8'h2B) || (chars.char_code == 8'h2D);
		cls.is_minus = (chars.char_code == 8'h2D);
		cls.is_zero  = (chars.char_code == 8'h30);
		cls.is_x     = (chars.char_code == 8'h78) || (chars.char_code == 8'h58);
		cls.start    = chars.start_flag;
	end
endmodule

// File: rtl/ttu_back.sv
`timescale 1ns / 1ps
module ttu_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  ttu_pkg::cls_t                item,
	input  logic [ttu_pkg::RADIX_W-1:0]  radix,
	ttu_result_if.source                 results
);
	import ttu_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_WS     = 3'd1;
	localparam logic [2:0] PH_BODY   = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_ZEROX  = 3'd4;
	localparam logic [2:0] PH_DIGITS = 3'd5;

	localparam logic [1:0] DS_NONE = 2'd0;
	localparam logic [1:0] DS_OK   = 2'd1;
	localparam logic [1:0] DS_OVER = 2'd2;

	localparam int MUL_W = VALUE_W + RADIX_W;

	logic [2:0]          phase_q;
	logic [VALUE_W-1:0]  acc_q;
	logic                minus_q;
	logic [RADIX_W-1:0]  base_q;
	logic [1:0]          ds_q;
	logic [OFFSET_W-1:0] pos_q;

	logic                out_valid_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [OFFSET_W-1:0] out_end_q;

	logic [2:0]          ph_in;
	logic [VALUE_W-1:0]  acc_in;
	logic                minus_in;
	logic [RADIX_W-1:0]  base_in;
	logic [1:0]          ds_in;
	logic [OFFSET_W-1:0] pos_in;
	logic [OFFSET_W-1:0] cur;
	logic [OFFSET_W-1:0] cur_inc;

	logic [2:0]          n_phase;
	logic [VALUE_W-1:0]  n_acc;
	logic                n_minus;
	logic [RADIX_W-1:0]  n_base;
	logic [1:0]          n_ds;
	logic [OFFSET_W-1:0] n_pos;

	logic                do_step;
	logic [RADIX_W-1:0]  st_base;
	logic [VALUE_W-1:0]  st_acc;
	logic [1:0]          st_ds;
	logic [RADIX_W-1:0]  alt_base;
	logic [MUL_W-1:0]    mul;
	logic                ovf;

	logic                emit;
	logic [VALUE_W-1:0]  e_value;
	logic [STATUS_W-1:0] e_status;
	logic [OFFSET_W-1:0] e_end;
	logic                fire;

	assign item_ready = !out_valid_q || results.ready;
	assign fire       = item_valid && item_ready;

	assign ph_in    = item.start ? PH_WS : phase_q;
	assign acc_in   = item.start ? '0 : acc_q;
	assign minus_in = item.start ? 1'b0 : minus_q;
	assign base_in  = item.start ? radix : base_q;
	assign ds_in    = item.start ? DS_NONE : ds_q;
	assign pos_in   = item.start ? '0 : pos_q;

	// the offset skips past the 'x' of a prefix once a hex digit follows
	assign cur     = (ph_in == PH_ZEROX && pos_in != '1) ? pos_in + 1'b1 : pos_in;
	assign cur_inc = (cur == '1) ? cur : cur + 1'b1;

	// a value fits when acc * base + digit stays inside 64 bits
	assign mul = {{RADIX_W{1'b0}}, st_acc} * {{VALUE_W{1'b0}}, st_base}
	             + {{VALUE_W{1'b0}}, item.digit};
	assign ovf = (mul[MUL_W-1:VALUE_W] != '0);

	always_comb begin
		n_phase  = ph_in;
		n_acc    = acc_in;
		n_minus  = minus_in;
		n_base   = base_in;
		n_ds     = ds_in;
		n_pos    = cur_inc;
		do_step  = 1'b0;
		st_base  = base_in;
		st_acc   = acc_in;
		st_ds    = ds_in;
		alt_base = base_in;
		emit     = 1'b0;
		e_value  = '0;
		e_status = ST_OK;
		e_end    = cur;

		case (ph_in)
			PH_IDLE: begin
				n_pos = pos_in;
			end
			PH_WS, PH_BODY: begin
				if (ph_in == PH_WS && item.is_ws) begin
					n_pos = cur_inc;
				end else if (ph_in == PH_WS && item.is_sign) begin
					n_minus = item.is_minus;
					n_phase = PH_BODY;
				end else if ((base_in == '0 || base_in == RADIX_W'(16)) && item.is_zero) begin
					n_phase = PH_ZERO;
				end else begin
					alt_base = (base_in == '0) ? RADIX_W'(10) : base_in;
					n_base   = alt_base;
					st_base  = alt_base;
					if (alt_base < RADIX_W'(2) || alt_base > RADIX_W'(36) ||
					    item.digit >= alt_base) begin
						emit     = 1'b1;
						e_status = ST_NOCONV;
						e_end    = '0;
					end else begin
						do_step = 1'b1;
					end
				end
			end
			PH_ZERO: begin
				if (item.is_x) begin
					n_phase = PH_ZEROX;
					n_pos   = cur;
				end else begin
					alt_base = (base_in == '0) ? RADIX_W'(8) : base_in;
					n_base   = alt_base;
					st_base  = alt_base;
					st_acc   = '0;
					st_ds    = DS_OK;
					do_step  = 1'b1;
				end
			end
			PH_ZEROX: begin
				if (item.digit < DIGIT_W'(16)) begin
					n_base  = RADIX_W'(16);
					st_base = RADIX_W'(16);
					do_step = 1'b1;
				end else begin
					// bare prefix: the leading zero is the number
					emit  = 1'b1;
					e_end = pos_in;
				end
			end
			default: begin
				do_step = 1'b1;
			end
		endcase

		if (do_step) begin
			n_acc = st_acc;
			n_ds  = st_ds;
			if (item.digit >= st_base) begin
				emit  = 1'b1;
				e_end = cur;
				if (st_ds == DS_OVER) begin
					e_value  = '1;
					e_status = ST_OVER;
				end else begin
					e_value  = minus_in ? VALUE_W'(0) - st_acc : st_acc;
					e_status = ST_OK;
				end
			end else begin
				if (st_ds == DS_OVER || ovf) begin
					n_ds = DS_OVER;
				end else begin
					n_acc = mul[VALUE_W-1:0];
					n_ds  = DS_OK;
				end
				n_phase = PH_DIGITS;
			end
		end

		if (emit) begin
			n_phase = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			acc_q       <= '0;
			minus_q     <= 1'b0;
			base_q      <= '0;
			ds_q        <= DS_NONE;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= n_phase;
				acc_q   <= n_acc;
				minus_q <= n_minus;
				base_q  <= n_base;
				ds_q    <= n_ds;
				pos_q   <= n_pos;
			end
			if (fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_value_q  <= e_value;
			out_status_q <= e_status;
			out_end_q    <= e_end;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.value      = out_value_q;
	assign results.status     = out_status_q;
	assign results.end_offset = out_end_q;
endmodule

// File: rtl/text_to_unsigned_integer_parser.sv
`timescale 1ns / 1ps
// streaming text to unsigned 64-bit parser, one character per request
// chars: char_code plus start_flag; start_flag marks the first character of a
//   string, drops any parse in progress and latches the radix register
// cfg: radix register (reset 10, 0 = auto-detect), to be written while idle
//   only; the user is bound to this, the block itself does not enforce it
// results: value, status (ok, overflow, no conversion) and end_offset, at most
//   one request per string, sent on the first character that ends the number
// throughput: one character per cycle, set by the digit unit in the back end
//   (one 64 x 6 multiply-add and fit check per character), unless stalled
// path: the terminating character is classified into the queue when accepted
//   and parsed into the result register once the back end pops it, after
//   any characters still queued ahead of it
// a stalled result holds in the output register and the back end takes no
//   further characters meanwhile; the queue behind the classifier (two
//   entries by default) then fills and drops chars.ready
// reset clears the queue, the parse state and the result valid; the block
//   then ignores characters until one arrives with start_flag set
module text_to_unsigned_integer_parser #(
	parameter int QUEUE_DEPTH = ttu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ttu_char_if.sink      chars,
	ttu_cfg_if.sink       cfg,
	ttu_result_if.source  results
);
	import ttu_pkg::*;

	localparam int CLS_W = $bits(cls_t);

	logic [RADIX_W-1:0] radix_q;
	cls_t               cls;
	logic               push;
	logic               q_ready;
	logic               pop_valid;
	logic               pop_ready;
	logic [CLS_W-1:0]   pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg.valid) begin
			radix_q <= cfg.radix;
		end
	end

	ttu_front u_front (
		.chars   (chars),
		.q_ready (q_ready),
		.push    (push),
		.cls     (cls)
	);

	ttu_queue #(
		.WIDTH (CLS_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push),
		.push_ready (q_ready),
		.push_data  (cls),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	ttu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.item       (cls_t'(pop_data)),
		.radix      (radix_q),
		.results    (results)
	);

`ifndef SYNTH
	a_noconv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status == ST_NOCONV |->
			results.value == '0 && results.end_offset == '0)
		else $error("no-conversion result with nonzero value or offset");

	a_over_ones: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status == ST_OVER |-> results.value == '1)
		else $error("overflow result not saturated");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.status != 2'd3)
		else $error("undefined status code");
`endif
endmodule
